// File: hw/rtl/ucs_pkg.sv
// shared types, constants and decode helpers for the serial command responder
// no dependencies
`timescale 1ns / 1ps

package ucs_pkg;

  localparam int unsigned BitPeriodWidth = 16;
  localparam int unsigned TickWidth      = 17;
  localparam int unsigned ModeWidth      = 3;
  localparam int unsigned BitIdxWidth    = 4;
  localparam int unsigned ReplyIdxWidth  = 3;

  localparam logic [BitPeriodWidth-1:0] BitPeriodReset = 16'd833;
  localparam logic [ModeWidth-1:0]      ModeReset      = 3'd1;

  localparam logic [BitIdxWidth-1:0]   RxLastBit    = 4'd8;
  localparam logic [BitIdxWidth-1:0]   TxDataLast   = 4'd8;
  localparam logic [BitIdxWidth-1:0]   TxFrameLast  = 4'd11;
  localparam logic [ReplyIdxWidth-1:0] ReplyLastIdx = 3'd4;
  localparam logic [ReplyIdxWidth-1:0] ReplyFirst   = 3'd1;

  // command bytes
  localparam logic [7:0] CmdKeepU = 8'h54;
  localparam logic [7:0] CmdKeepL = 8'h74;
  localparam logic [7:0] CmdOff   = 8'h30;
  localparam logic [7:0] CmdDiv1  = 8'h31;
  localparam logic [7:0] CmdDiv2  = 8'h32;
  localparam logic [7:0] CmdDiv4  = 8'h34;
  localparam logic [7:0] CmdDiv8  = 8'h38;
  localparam logic [7:0] CmdHighU = 8'h48;
  localparam logic [7:0] CmdHighL = 8'h68;
  localparam logic [7:0] CmdLowU  = 8'h4C;
  localparam logic [7:0] CmdLowL  = 8'h6C;

  typedef enum logic [2:0] {
    PH_WAIT_IDLE = 3'd0,
    PH_HUNT      = 3'd1,
    PH_START     = 3'd2,
    PH_DATA      = 3'd3,
    PH_STOP      = 3'd4,
    PH_SEND      = 3'd5
  } ucs_phase_e;

  typedef enum logic [ModeWidth-1:0] {
    MODE_OFF  = 3'd0,
    MODE_HIGH = 3'd1,
    MODE_LOW  = 3'd2,
    MODE_DIV1 = 3'd3,
    MODE_DIV2 = 3'd4,
    MODE_DIV4 = 3'd5,
    MODE_DIV8 = 3'd6
  } ucs_mode_e;

  typedef struct packed {
    logic      is_cmd;
    logic      set_mode;
    ucs_mode_e mode;
  } ucs_cmd_t;

  function automatic ucs_cmd_t ucs_decode(input logic [7:0] c);
    ucs_cmd_t r;
    r.is_cmd   = 1'b1;
    r.set_mode = 1'b1;
    r.mode     = MODE_OFF;
    case (c)
      CmdKeepU, CmdKeepL: r.set_mode = 1'b0;
      CmdOff:             r.mode = MODE_OFF;
      CmdDiv1:            r.mode = MODE_DIV1;
      CmdDiv2:            r.mode = MODE_DIV2;
      CmdDiv4:            r.mode = MODE_DIV4;
      CmdDiv8:            r.mode = MODE_DIV8;
      CmdHighU, CmdHighL: r.mode = MODE_HIGH;
      CmdLowU, CmdLowL:   r.mode = MODE_LOW;
      default: begin
        r.is_cmd   = 1'b0;
        r.set_mode = 1'b0;
      end
    endcase
    return r;
  endfunction

  // reply text "OK" cr lf
  function automatic logic [7:0] ucs_reply_text(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h4F;
      2'd1:    ch = 8'h4B;
      2'd2:    ch = 8'h0D;
      default: ch = 8'h0A;
    endcase
    return ch;
  endfunction

endpackage

// File: hw/rtl/uart_command_clock_selector.sv
// top level of the serial command responder: sample queue feeding the engine
// depends on ucs_pkg, ucs_rx_queue, ucs_engine
// path: an accepted request is queued, then an engine step registers its result
// throughput: one request per cycle unless stalled, set by the single-step engine
// reset: asynchronous active low; bit period 833, mode reg drive high, queue empty
`timescale 1ns / 1ps

module uart_command_clock_selector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                bit_period_we_i,
  input  logic [ucs_pkg::BitPeriodWidth-1:0]  bit_period_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                rx_line_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                tx_line_o,
  output logic [ucs_pkg::ModeWidth-1:0]       pin_mode_o,
  output logic                                reply_busy_o
);
  import ucs_pkg::*;

  logic q_valid;
  logic q_pop;
  logic q_rx;

  ucs_rx_queue u_rx_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_line_i  (rx_line_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_rx_o     (q_rx)
  );

  ucs_engine u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .bit_period_we_i (bit_period_we_i),
    .bit_period_i    (bit_period_i),
    .q_valid_i       (q_valid),
    .q_pop_o         (q_pop),
    .q_rx_i          (q_rx),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .tx_line_o       (tx_line_o),
    .pin_mode_o      (pin_mode_o),
    .reply_busy_o    (reply_busy_o)
  );

endmodule

// File: hw/rtl/ucs_rx_queue.sv
// front end: takes receive line samples and holds them in a two-entry queue
// no package dependencies
`timescale 1ns / 1ps

module ucs_rx_queue (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic rx_line_i,
  output logic q_valid_o,
  input  logic q_pop_i,
  output logic q_rx_o
);

  logic [1:0] mem_q;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign in_ready_o = (count_q != 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_rx_o     = mem_q[rd_ptr_q];

  assign push = in_valid_i & in_ready_o;
  assign pop  = q_pop_i & q_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= rx_line_i;
    end
  end

endmodule

// File: hw/rtl/ucs_engine.sv
// back end: receive and reply state machine, one queued sample per step,
// with the result register; depends on ucs_pkg
`timescale 1ns / 1ps

module ucs_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                bit_period_we_i,
  input  logic [ucs_pkg::BitPeriodWidth-1:0]  bit_period_i,
  input  logic                                q_valid_i,
  output logic                                q_pop_o,
  input  logic                                q_rx_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                tx_line_o,
  output logic [ucs_pkg::ModeWidth-1:0]       pin_mode_o,
  output logic                                reply_busy_o
);
  import ucs_pkg::*;

  logic [BitPeriodWidth-1:0] bit_period_q;
  ucs_phase_e                phase_q, phase_d;
  logic [TickWidth-1:0]      tick_q, tick_d;
  logic [BitIdxWidth-1:0]    bit_idx_q, bit_idx_d;
  logic [7:0]                rx_shift_q, rx_shift_d;
  logic [7:0]                tx_shift_q, tx_shift_d;
  logic [ReplyIdxWidth-1:0]  reply_q, reply_d;
  logic [ModeWidth-1:0]      mode_q, mode_d;
  logic                      out_valid_q;
  logic                      tx_q, tx_d;
  logic [ModeWidth-1:0]      pin_mode_q;
  logic                      busy_q;

  logic                      step;
  logic [TickWidth-1:0]      tick_inc, bp_full, bp_half;
  logic [BitIdxWidth-1:0]    bit_inc;
  logic [BitIdxWidth-1:0]    tx_sel;
  ucs_cmd_t                  cmd;

  assign step     = q_valid_i & (~out_valid_q | out_ready_i);
  assign q_pop_o  = step;
  assign tick_inc = tick_q + TickWidth'(1);
  assign bp_full  = TickWidth'(bit_period_q);
  assign bp_half  = TickWidth'(bit_period_q[BitPeriodWidth-1:1]);
  assign bit_inc  = bit_idx_q + BitIdxWidth'(1);
  assign cmd      = ucs_decode(rx_shift_q);
  assign tx_sel   = bit_idx_d - BitIdxWidth'(1);

  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    bit_idx_d  = bit_idx_q;
    rx_shift_d = rx_shift_q;
    tx_shift_d = tx_shift_q;
    reply_d    = reply_q;
    mode_d     = mode_q;
    case (phase_q)
      PH_HUNT: begin
        if (!q_rx_i) begin
          phase_d = PH_START;
          tick_d  = '0;
        end
      end
      PH_START: begin
        tick_d = tick_inc;
        if (tick_inc >= bp_half) begin
          if (q_rx_i) begin
            phase_d = PH_WAIT_IDLE;
          end else begin
            phase_d   = PH_DATA;
            tick_d    = '0;
            bit_idx_d = '0;
          end
        end
      end
      PH_DATA: begin
        tick_d = tick_inc;
        if (tick_inc >= bp_full) begin
          tick_d     = '0;
          rx_shift_d = {q_rx_i, rx_shift_q[7:1]};
          bit_idx_d  = bit_inc;
          if (bit_inc >= RxLastBit) begin
            phase_d = PH_STOP;
          end
        end
      end
      PH_STOP: begin
        tick_d = tick_inc;
        if (tick_inc >= bp_full) begin
          tick_d = '0;
          if (!q_rx_i) begin
            phase_d = PH_WAIT_IDLE;
          end else if (!cmd.is_cmd) begin
            phase_d = PH_HUNT;
          end else begin
            if (cmd.set_mode) begin
              mode_d = cmd.mode;
            end
            phase_d    = PH_SEND;
            reply_d    = ReplyFirst;
            tx_shift_d = ucs_reply_text(2'd0);
            bit_idx_d  = '0;
          end
        end
      end
      PH_SEND: begin
        tick_d = tick_inc;
        if (tick_inc >= bp_full) begin
          tick_d    = '0;
          bit_idx_d = bit_inc;
          if (bit_inc >= TxFrameLast) begin
            bit_idx_d = '0;
            if (reply_q >= ReplyLastIdx || reply_q == '0) begin
              reply_d = '0;
              phase_d = PH_WAIT_IDLE;
            end else begin
              reply_d    = reply_q + ReplyIdxWidth'(1);
              tx_shift_d = ucs_reply_text(reply_q[1:0]);
            end
          end
        end
      end
      default: begin
        phase_d = q_rx_i ? PH_HUNT : PH_WAIT_IDLE;
      end
    endcase
  end

  always_comb begin
    tx_d = 1'b1;
    if (phase_d == PH_SEND) begin
      if (bit_idx_d == '0) begin
        tx_d = 1'b0;
      end else if (bit_idx_d <= TxDataLast) begin
        tx_d = tx_shift_d[tx_sel[2:0]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q <= BitPeriodReset;
    end else if (bit_period_we_i) begin
      bit_period_q <= bit_period_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_WAIT_IDLE;
      tick_q     <= '0;
      bit_idx_q  <= '0;
      rx_shift_q <= '0;
      tx_shift_q <= '0;
      reply_q    <= '0;
      mode_q     <= ModeReset;
    end else if (step) begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      bit_idx_q  <= bit_idx_d;
      rx_shift_q <= rx_shift_d;
      tx_shift_q <= tx_shift_d;
      reply_q    <= reply_d;
      mode_q     <= mode_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      tx_q       <= tx_d;
      pin_mode_q <= mode_d;
      busy_q     <= (phase_d == PH_SEND);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tx_line_o    = tx_q;
  assign pin_mode_o   = pin_mode_q;
  assign reply_busy_o = busy_q;

endmodule
